### design/phs_pkg.sv
// Shared types and constants of the printable character histogram sorter.
`timescale 1ns / 1ps

package phs_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int NUM_BINS    = 94;
    localparam int BIN_BITS    = $clog2(NUM_BINS);
    localparam int FIRST_CODE  = 33;
    localparam int LAST_CODE   = 126;
    localparam int CODE_BITS   = 7;
    localparam int OUT_BITS    = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [BIN_BITS-1:0]   LAST_BIN  = BIN_BITS'(NUM_BINS - 1);

    typedef enum logic [1:0] {
        MODE_COUNT = 2'd0,
        MODE_SORT  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OP_COUNT,
        OP_SORT,
        OP_READ,
        OP_READ_NULL,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [BIN_BITS-1:0] arg;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_WR,
        ST_RD_ORDER,
        ST_RD_COUNT,
        ST_SORT_KEY,
        ST_SORT_LOAD,
        ST_SORT_SCAN
    } state_t;

endpackage

### design/phs_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module phs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/phs_queue.sv
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module phs_queue
    import phs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head_entry,
    output q_status_t status
);

    q_entry_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS:0]     fill_reg;
    logic [QPTR_BITS:0]     fill_next;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry   = entry_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);

`ifndef SYNTH
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue pushed while full");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (QPTR_BITS + 1)'(QUEUE_DEPTH))
        else $error("queue fill level out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_BITS'(wr_ptr_reg - rd_ptr_reg) == QPTR_BITS'(fill_reg))
        else $error("queue pointers disagree with fill level");
`endif

endmodule

### design/phs_front.sv
// Front part: accepts input words and turns them into queue commands.
`timescale 1ns / 1ps

module phs_front
    import phs_pkg::*;
(
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [7:0]           byte_value,
    input  logic [6:0]           rank,
    input  q_status_t            q_status,
    output logic                 q_push,
    output q_entry_t             q_entry
);

    logic keep;

    always_comb
    begin
        keep        = 1'b1;
        q_entry.op  = OP_CLEAR;
        q_entry.arg = '0;
        case (mode_t'(mode))
            MODE_COUNT:
            begin
                // Bytes outside the printable range are dropped here.
                keep        = byte_value inside {[FIRST_CODE:LAST_CODE]};
                q_entry.op  = OP_COUNT;
                q_entry.arg = BIN_BITS'(byte_value - 8'(FIRST_CODE));
            end
            MODE_SORT:
            begin
                q_entry.op = OP_SORT;
            end
            MODE_READ:
            begin
                if (rank < 7'(NUM_BINS))
                begin
                    q_entry.op  = OP_READ;
                    q_entry.arg = BIN_BITS'(rank);
                end
                else
                begin
                    q_entry.op = OP_READ_NULL;
                end
            end
            default:
            begin
                q_entry.op = OP_CLEAR;
            end
        endcase
    end

    assign in_stall = q_status.full;
    assign q_push   = in_valid && !q_status.full && keep;

endmodule

### design/phs_back.sv
// Back part: counts, sorts by rank and answers reads against the bin memories.
`timescale 1ns / 1ps

module phs_back
    import phs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  q_status_t            q_status,
    input  q_entry_t             q_entry,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CODE_BITS-1:0] char_code,
    output logic [OUT_BITS-1:0]  char_count
);

    state_t                state_reg, state_next;
    logic [BIN_BITS-1:0]   bin_reg, bin_next;
    logic [BIN_BITS-1:0]   i_reg, i_next;
    logic [BIN_BITS-1:0]   j_reg, j_next;
    logic [BIN_BITS-1:0]   pos_reg, pos_next;
    logic [COUNT_BITS-1:0] key_reg, key_next;
    logic                  null_reg, null_next;
    logic                  order_valid_reg, order_valid_next;
    logic                  cnt_vld_reg [NUM_BINS];
    logic                  cnt_rd_vld_reg;
    logic                  out_vld_reg;
    logic [CODE_BITS-1:0]  out_code_reg;
    logic [OUT_BITS-1:0]   out_count_reg;

    logic                  cnt_wr_en, cnt_rd_en;
    logic [BIN_BITS-1:0]   cnt_wr_addr, cnt_rd_addr;
    logic [COUNT_BITS-1:0] cnt_wr_data, cnt_rd_data, cnt_val;
    logic                  ord_wr_en, ord_rd_en;
    logic [BIN_BITS-1:0]   ord_wr_addr, ord_wr_data, ord_rd_addr, ord_rd_data;
    logic                  clear_all, out_load, out_free, goes_before;
    logic [CODE_BITS-1:0]  out_code_next;
    logic [OUT_BITS-1:0]   out_count_next;

    phs_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_count_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    phs_ram #(.WIDTH(BIN_BITS), .DEPTH(NUM_BINS)) u_order_ram (
        .clk     (clk),
        .wr_en   (ord_wr_en),
        .wr_addr (ord_wr_addr),
        .wr_data (ord_wr_data),
        .rd_en   (ord_rd_en),
        .rd_addr (ord_rd_addr),
        .rd_data (ord_rd_data)
    );

    // A bin that has not been written since the last clear reads as zero.
    assign cnt_val  = cnt_rd_vld_reg ? cnt_rd_data : '0;
    assign out_free = !out_vld_reg || !out_stall;

    // Strict order: lower count first, then lower bin index.
    assign goes_before = (cnt_val < key_reg) || ((cnt_val == key_reg) && (j_reg < i_reg));

    always_comb
    begin
        state_next       = state_reg;
        bin_next         = bin_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        pos_next         = pos_reg;
        key_next         = key_reg;
        null_next        = null_reg;
        order_valid_next = order_valid_reg;
        q_pop            = 1'b0;
        clear_all        = 1'b0;
        cnt_wr_en        = 1'b0;
        cnt_wr_addr      = bin_reg;
        cnt_wr_data      = (cnt_val == COUNT_MAX) ? cnt_val : cnt_val + COUNT_BITS'(1);
        cnt_rd_en        = 1'b0;
        cnt_rd_addr      = q_entry.arg;
        ord_wr_en        = 1'b0;
        ord_wr_addr      = '0;
        ord_wr_data      = i_reg;
        ord_rd_en        = 1'b0;
        ord_rd_addr      = q_entry.arg;
        out_load         = 1'b0;
        out_code_next    = '0;
        out_count_next   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop = 1'b1;
                    case (q_entry.op)
                        OP_COUNT:
                        begin
                            cnt_rd_en  = 1'b1;
                            bin_next   = q_entry.arg;
                            state_next = ST_CNT_WR;
                        end
                        OP_SORT:
                        begin
                            i_next     = '0;
                            state_next = ST_SORT_KEY;
                        end
                        OP_READ:
                        begin
                            null_next = 1'b0;
                            if (order_valid_reg)
                            begin
                                ord_rd_en  = 1'b1;
                                state_next = ST_RD_ORDER;
                            end
                            else
                            begin
                                cnt_rd_en  = 1'b1;
                                bin_next   = q_entry.arg;
                                state_next = ST_RD_COUNT;
                            end
                        end
                        OP_READ_NULL:
                        begin
                            null_next  = 1'b1;
                            state_next = ST_RD_COUNT;
                        end
                        default:
                        begin
                            clear_all        = 1'b1;
                            order_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_CNT_WR:
            begin
                cnt_wr_en        = 1'b1;
                order_valid_next = 1'b0;
                state_next       = ST_IDLE;
            end
            ST_RD_ORDER:
            begin
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = ord_rd_data;
                bin_next    = ord_rd_data;
                state_next  = ST_RD_COUNT;
            end
            ST_RD_COUNT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (!null_reg)
                    begin
                        out_count_next = OUT_BITS'(cnt_val);
                        if (cnt_val != '0)
                        begin
                            out_code_next = CODE_BITS'(bin_reg) + CODE_BITS'(FIRST_CODE);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SORT_KEY:
            begin
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = i_reg;
                state_next  = ST_SORT_LOAD;
            end
            ST_SORT_LOAD:
            begin
                key_next    = cnt_val;
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = '0;
                j_next      = '0;
                pos_next    = '0;
                state_next  = ST_SORT_SCAN;
            end
            ST_SORT_SCAN:
            begin
                // The rank of bin i is the number of bins that go before it.
                pos_next = pos_reg + BIN_BITS'(goes_before);
                if (j_reg == LAST_BIN)
                begin
                    ord_wr_en   = 1'b1;
                    ord_wr_addr = pos_next;
                    if (i_reg == LAST_BIN)
                    begin
                        order_valid_next = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_SORT_KEY;
                    end
                end
                else
                begin
                    j_next      = j_reg + 1'b1;
                    cnt_rd_en   = 1'b1;
                    cnt_rd_addr = j_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            order_valid_reg <= 1'b0;
            out_vld_reg     <= 1'b0;
            cnt_rd_vld_reg  <= 1'b0;
            for (int k = 0; k < NUM_BINS; k++)
            begin
                cnt_vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            order_valid_reg <= order_valid_next;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cnt_rd_en)
            begin
                cnt_rd_vld_reg <= cnt_vld_reg[cnt_rd_addr];
            end
            if (clear_all)
            begin
                for (int k = 0; k < NUM_BINS; k++)
                begin
                    cnt_vld_reg[k] <= 1'b0;
                end
            end
            else if (cnt_wr_en)
            begin
                cnt_vld_reg[cnt_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        pos_reg  <= pos_next;
        key_reg  <= key_next;
        null_reg <= null_next;
        if (out_load)
        begin
            out_code_reg  <= out_code_next;
            out_count_reg <= out_count_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign char_code  = out_code_reg;
    assign char_count = out_count_reg;

`ifndef SYNTH
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT_SCAN) |-> (pos_reg <= j_reg))
        else $error("sort rank exceeds scanned bins");
    a_order_after_sort: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(order_valid_reg) |-> $past(state_reg == ST_SORT_SCAN && i_reg == LAST_BIN))
        else $error("order marked valid outside the end of a sort");
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == ST_RD_COUNT))
        else $error("result raised outside a read");
    a_code_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ((out_code_reg == '0) == (out_count_reg == '0)))
        else $error("character code and count disagree on an empty bin");
`endif

endmodule

### design/printable_char_histogram_sort.sv
// Top level of the printable character histogram with rank sort.
`timescale 1ns / 1ps

// Counts printable ASCII bytes (codes 33 to 126) into 94 saturating bins and
// sorts them by count on request. The front accepts one word per cycle into a
// four-entry command queue and drops non-printable bytes there without using
// the back part. The back part works on one command at a time against a count
// memory with one write port and one read port: a counted byte is read, then
// written back with the incremented count; a read goes to the count memory in
// bin order, or after a sort to the order memory and then the count memory,
// and its result may wait at the output; and a sort finds every bin's rank by
// one pass over all counts. Once the queue is full, input is stalled until the
// back part frees an entry. Reset and clear empty the bins at once through
// per-bin valid bits.
module printable_char_histogram_sort
    import phs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [7:0]           byte_value,
    input  logic [6:0]           rank,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CODE_BITS-1:0] char_code,
    output logic [OUT_BITS-1:0]  char_count
);

    q_status_t q_status;
    q_entry_t  push_entry;
    q_entry_t  head_entry;
    logic      q_push;
    logic      q_pop;

    phs_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .byte_value (byte_value),
        .rank       (rank),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    phs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    phs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_entry    (head_entry),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .char_count (char_count)
    );

endmodule
